### sv/gjk_simplex_update_top_defines.svh
// Assertion macros for the GJK simplex update block.
`ifndef GJK_SIMPLEX_UPDATE_TOP_DEFINES_SVH
`define GJK_SIMPLEX_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset
`define GSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition on one edge implies a condition on the next edge
`define GSU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define GSU_ASSERT(lbl, prop, msg)
`define GSU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/gsu_pkg.sv
// Shared constants, types and command codes for the GJK simplex update block.
package gsu_pkg;

  localparam int COORD_BITS = 16;
  localparam int NW         = COORD_BITS + 1;   // point differences and negated points
  localparam int ABCW       = 2 * NW + 1;       // cross product of two differences
  localparam int TW         = ABCW + NW + 1;    // cross of a face normal with an edge
  localparam int DW         = 56;               // search direction components
  localparam int PW         = DW + NW;          // one product
  localparam int AW         = PW + 2;           // sum of three products
  localparam int CNT_W      = 3;

  localparam logic [CNT_W-1:0] MAX_PTS = 3'd4;

  typedef logic [2:0][COORD_BITS-1:0] pt_t;
  typedef logic [2:0][DW-1:0]         dir_t;

  typedef enum logic [1:0] {
    ST_CONT = 2'd0,
    ST_MISS = 2'd1,
    ST_HIT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_START, OP_PUSH, OP_LOAD, OP_LINE_KEEP, OP_LINE_DROP,
    OP_EDGE_AC, OP_TRI_UP, OP_TRI_DN, OP_CROSS, OP_DOT
  } op_e;

  typedef enum logic [2:0] {U_DIR, U_ABC, U_T, U_AB, U_AC} usel_e;
  typedef enum logic [1:0] {V_AB, V_AC, V_AO, V_PT} vsel_e;
  typedef enum logic [1:0] {D_ABC, D_T, D_DIR} dst_e;

  // Working-triangle orderings of the held points
  localparam logic [1:0] PERM_ABC  = 2'd0;
  localparam logic [1:0] PERM_ACD  = 2'd1;
  localparam logic [1:0] PERM_ADB  = 2'd2;
  localparam logic [1:0] LAST_FACE = PERM_ADB;

  typedef struct packed {
    op_e        op;
    usel_e      usel;
    vsel_e      vsel;
    dst_e       dst;
    logic [1:0] perm;
    logic       take_pt;
  } cmd_t;

  typedef struct packed {
    logic             done;
    logic             pos;
    logic             neg;
    logic [CNT_W-1:0] cnt;
  } dp_stat_t;

endpackage

### sv/gsu_datapath.sv
// Datapath: simplex registers, working triangle and the shared multiply-accumulate unit.
module gsu_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gsu_pkg::cmd_t     cmd_i,
  input  gsu_pkg::pt_t      pt_i,
  output gsu_pkg::dp_stat_t stat_o,
  output gsu_pkg::dir_t     dir_o
);

  gsu_pkg::pt_t                      pt_q, wa_q, wb_q, wc_q;
  gsu_pkg::pt_t [3:0]                s_q;
  logic [gsu_pkg::CNT_W-1:0]         cnt_q;
  gsu_pkg::dir_t                     dir_q;
  logic [2:0][gsu_pkg::ABCW-1:0]     abc_q;
  logic [2:0][gsu_pkg::TW-1:0]       t_q;
  logic [2:0][gsu_pkg::NW-1:0]       ab, ac, ao, ptn;
  logic [2:0][gsu_pkg::DW-1:0]       u_vec;
  logic [2:0][gsu_pkg::NW-1:0]       v_vec;
  logic                              busy_q, dot_q;
  logic [2:0]                        k_q;
  gsu_pkg::usel_e                    usel_q;
  gsu_pkg::vsel_e                    vsel_q;
  gsu_pkg::dst_e                     dst_q;
  logic [1:0]                        comp, nx1, nx2, iu, iv;
  logic                              term, go, last_k, fin;
  logic signed [gsu_pkg::DW-1:0]     u_op;
  logic signed [gsu_pkg::NW-1:0]     v_op;
  logic signed [gsu_pkg::PW-1:0]     prod_d, prod_q;
  logic                              pv_q, pneg_q, pfirst_q, plast_q, pdot_q;
  logic [1:0]                        pcomp_q;
  logic signed [gsu_pkg::AW-1:0]     acc_q, addend, sum;
  logic                              done_q, pos_q, neg_q;

  function automatic logic [1:0] next3(input logic [1:0] i);
    case (i)
      2'd0:    next3 = 2'd1;
      2'd1:    next3 = 2'd2;
      default: next3 = 2'd0;
    endcase
  endfunction

  function automatic logic [gsu_pkg::NW-1:0] sxn(input logic [gsu_pkg::COORD_BITS-1:0] c);
    sxn = {c[gsu_pkg::COORD_BITS-1], c};
  endfunction

  function automatic logic [gsu_pkg::DW-1:0] sxw(input logic [gsu_pkg::NW-1:0] c);
    sxw = {{(gsu_pkg::DW-gsu_pkg::NW){c[gsu_pkg::NW-1]}}, c};
  endfunction

  function automatic logic [gsu_pkg::DW-1:0] sxa(input logic [gsu_pkg::ABCW-1:0] c);
    sxa = {{(gsu_pkg::DW-gsu_pkg::ABCW){c[gsu_pkg::ABCW-1]}}, c};
  endfunction

  function automatic logic [gsu_pkg::DW-1:0] sxt(input logic [gsu_pkg::TW-1:0] c);
    sxt = {{(gsu_pkg::DW-gsu_pkg::TW){c[gsu_pkg::TW-1]}}, c};
  endfunction

  // Edge vectors of the working triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i]  = sxn(wb_q[i]) - sxn(wa_q[i]);
      ac[i]  = sxn(wc_q[i]) - sxn(wa_q[i]);
      ao[i]  = gsu_pkg::NW'(0) - sxn(wa_q[i]);
      ptn[i] = sxn(pt_q[i]);
    end
  end

  // Operand vector selection
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (usel_q)
        gsu_pkg::U_DIR: u_vec[i] = dir_q[i];
        gsu_pkg::U_ABC: u_vec[i] = sxa(abc_q[i]);
        gsu_pkg::U_T:   u_vec[i] = sxt(t_q[i]);
        gsu_pkg::U_AB:  u_vec[i] = sxw(ab[i]);
        gsu_pkg::U_AC:  u_vec[i] = sxw(ac[i]);
        default:        u_vec[i] = '0;
      endcase
      case (vsel_q)
        gsu_pkg::V_AB: v_vec[i] = ab[i];
        gsu_pkg::V_AC: v_vec[i] = ac[i];
        gsu_pkg::V_AO: v_vec[i] = ao[i];
        default:       v_vec[i] = ptn[i];
      endcase
    end
  end

  // Component sequencing: cross takes two terms per component, dot one per axis
  assign comp   = k_q[2:1];
  assign term   = k_q[0];
  assign nx1    = next3(comp);
  assign nx2    = next3(nx1);
  assign iu     = dot_q ? k_q[1:0] : (term ? nx2 : nx1);
  assign iv     = dot_q ? k_q[1:0] : (term ? nx1 : nx2);
  assign u_op   = u_vec[iu];
  assign v_op   = v_vec[iv];
  assign prod_d = u_op * v_op;
  assign last_k = dot_q ? (k_q == 3'd2) : (k_q == 3'd5);
  assign go     = (cmd_i.op == gsu_pkg::OP_CROSS) || (cmd_i.op == gsu_pkg::OP_DOT);

  // Accumulate stage
  assign addend = pneg_q ? -gsu_pkg::AW'(prod_q) : gsu_pkg::AW'(prod_q);
  assign sum    = (pfirst_q ? '0 : acc_q) + addend;
  assign fin    = pv_q && plast_q && (pdot_q || (pcomp_q == 2'd2));

  // Control state, count and direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dir_q  <= '0;
    end else begin
      pv_q   <= busy_q;
      done_q <= fin;
      if (go) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 3'd1;
        if (last_k) busy_q <= 1'b0;
      end
      if (pv_q && plast_q && !pdot_q && (dst_q == gsu_pkg::D_DIR)) begin
        dir_q[pcomp_q] <= sum[gsu_pkg::DW-1:0];
      end
      case (cmd_i.op)
        gsu_pkg::OP_START: begin
          cnt_q <= 3'd1;
          for (int i = 0; i < 3; i++) dir_q[i] <= gsu_pkg::DW'(0) - sxw(ptn[i]);
        end
        gsu_pkg::OP_PUSH: cnt_q <= (cnt_q == gsu_pkg::MAX_PTS) ? gsu_pkg::MAX_PTS
                                                               : cnt_q + 3'd1;
        gsu_pkg::OP_LINE_KEEP: cnt_q <= 3'd2;
        gsu_pkg::OP_LINE_DROP: begin
          cnt_q <= 3'd1;
          for (int i = 0; i < 3; i++) dir_q[i] <= sxw(ao[i]);
        end
        gsu_pkg::OP_EDGE_AC: cnt_q <= 3'd2;
        gsu_pkg::OP_TRI_UP: begin
          cnt_q <= 3'd3;
          for (int i = 0; i < 3; i++) dir_q[i] <= sxa(abc_q[i]);
        end
        gsu_pkg::OP_TRI_DN: begin
          cnt_q <= 3'd3;
          for (int i = 0; i < 3; i++) dir_q[i] <= gsu_pkg::DW'(0) - sxa(abc_q[i]);
        end
        default: ;
      endcase
    end
  end

  // Points, working triangle, operand latches and multiplier pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pt) pt_q <= pt_i;
    case (cmd_i.op)
      gsu_pkg::OP_START: s_q[0] <= pt_q;
      gsu_pkg::OP_PUSH: begin
        s_q[3] <= s_q[2];
        s_q[2] <= s_q[1];
        s_q[1] <= s_q[0];
        s_q[0] <= pt_q;
      end
      gsu_pkg::OP_LOAD: begin
        wa_q <= s_q[0];
        case (cmd_i.perm)
          gsu_pkg::PERM_ABC: begin wb_q <= s_q[1]; wc_q <= s_q[2]; end
          gsu_pkg::PERM_ACD: begin wb_q <= s_q[2]; wc_q <= s_q[3]; end
          default:           begin wb_q <= s_q[3]; wc_q <= s_q[1]; end
        endcase
      end
      gsu_pkg::OP_LINE_KEEP: begin s_q[0] <= wa_q; s_q[1] <= wb_q; end
      gsu_pkg::OP_LINE_DROP: s_q[0] <= wa_q;
      gsu_pkg::OP_EDGE_AC:   begin s_q[0] <= wa_q; s_q[1] <= wc_q; end
      gsu_pkg::OP_TRI_UP: begin s_q[0] <= wa_q; s_q[1] <= wb_q; s_q[2] <= wc_q; end
      gsu_pkg::OP_TRI_DN: begin s_q[0] <= wa_q; s_q[1] <= wc_q; s_q[2] <= wb_q; end
      default: ;
    endcase
    if (go) begin
      dot_q  <= (cmd_i.op == gsu_pkg::OP_DOT);
      usel_q <= cmd_i.usel;
      vsel_q <= cmd_i.vsel;
      dst_q  <= cmd_i.dst;
    end
    prod_q   <= prod_d;
    pneg_q   <= !dot_q && term;
    pfirst_q <= dot_q ? (k_q == 3'd0) : !term;
    plast_q  <= dot_q ? (k_q == 3'd2) : term;
    pcomp_q  <= comp;
    pdot_q   <= dot_q;
    if (pv_q) begin
      acc_q <= sum;
      if (plast_q && !pdot_q) begin
        case (dst_q)
          gsu_pkg::D_ABC: abc_q[pcomp_q] <= sum[gsu_pkg::ABCW-1:0];
          gsu_pkg::D_T:   t_q[pcomp_q]   <= sum[gsu_pkg::TW-1:0];
          default: ;
        endcase
      end
    end
    if (fin) begin
      neg_q <= sum[gsu_pkg::AW-1];
      pos_q <= !sum[gsu_pkg::AW-1] && (sum != '0);
    end
  end

  assign stat_o = '{done: done_q, pos: pos_q, neg: neg_q, cnt: cnt_q};
  assign dir_o  = dir_q;

endmodule

### sv/gsu_ctrl.sv
// Controller: sequences the direction check, push and line/triangle/tetrahedron tests.
module gsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  input  logic              out_ready_i,
  input  gsu_pkg::dp_stat_t stat_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output gsu_pkg::status_e  status_o,
  output gsu_pkg::cmd_t     cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_START   = 18'h00002,
    S_PD      = 18'h00004,
    S_DISP    = 18'h00008,
    S_LINE_D  = 18'h00010,
    S_LINE_C1 = 18'h00020,
    S_LINE_C2 = 18'h00040,
    S_FACE_C  = 18'h00080,
    S_FACE_D  = 18'h00100,
    S_TRI_C1  = 18'h00200,
    S_TRI_D1  = 18'h00400,
    S_TRI_D2  = 18'h00800,
    S_EDGE_C1 = 18'h01000,
    S_EDGE_C2 = 18'h02000,
    S_TRI_C3  = 18'h04000,
    S_TRI_D3  = 18'h08000,
    S_TRI_D4  = 18'h10000,
    S_OUT     = 18'h20000
  } state_e;

  state_e           state_q, state_d;
  logic             sent_q, sent_d, tetra_q, tetra_d;
  logic [1:0]       face_q, face_d;
  gsu_pkg::status_e status_q, status_d;
  gsu_pkg::op_e     mop;

  always_comb begin
    state_d  = state_q;
    sent_d   = sent_q;
    tetra_d  = tetra_q;
    face_d   = face_q;
    status_d = status_q;
    mop      = gsu_pkg::OP_NONE;
    cmd_o    = '{op: gsu_pkg::OP_NONE, usel: gsu_pkg::U_DIR, vsel: gsu_pkg::V_AB,
                 dst: gsu_pkg::D_T, perm: gsu_pkg::PERM_ABC, take_pt: 1'b0};

    // Operand selection for the multi-cycle states
    case (state_q)
      S_PD:      begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_DIR;
                       cmd_o.vsel = gsu_pkg::V_PT; end
      S_LINE_D:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_AB;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      S_LINE_C1: begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_AB;
                       cmd_o.vsel = gsu_pkg::V_AO; cmd_o.dst = gsu_pkg::D_T; end
      S_LINE_C2: begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_T;
                       cmd_o.vsel = gsu_pkg::V_AB; cmd_o.dst = gsu_pkg::D_DIR; end
      S_FACE_C:  begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_AB;
                       cmd_o.vsel = gsu_pkg::V_AC; cmd_o.dst = gsu_pkg::D_ABC; end
      S_FACE_D:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_ABC;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      S_TRI_C1:  begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_ABC;
                       cmd_o.vsel = gsu_pkg::V_AC; cmd_o.dst = gsu_pkg::D_T; end
      S_TRI_D1:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_T;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      S_TRI_D2:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_AC;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      S_EDGE_C1: begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_AC;
                       cmd_o.vsel = gsu_pkg::V_AO; cmd_o.dst = gsu_pkg::D_T; end
      S_EDGE_C2: begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_T;
                       cmd_o.vsel = gsu_pkg::V_AC; cmd_o.dst = gsu_pkg::D_DIR; end
      S_TRI_C3:  begin mop = gsu_pkg::OP_CROSS; cmd_o.usel = gsu_pkg::U_ABC;
                       cmd_o.vsel = gsu_pkg::V_AB; cmd_o.dst = gsu_pkg::D_T; end
      S_TRI_D3:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_T;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      S_TRI_D4:  begin mop = gsu_pkg::OP_DOT;   cmd_o.usel = gsu_pkg::U_ABC;
                       cmd_o.vsel = gsu_pkg::V_AO; end
      default: ;
    endcase

    // Issue once, then wait for the unit to finish
    if (mop != gsu_pkg::OP_NONE) begin
      if (!sent_q) cmd_o.op = mop;
      sent_d = !stat_i.done;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_pt = 1'b1;
          state_d = in_op_i ? S_PD : S_START;
        end
      end
      S_START: begin
        cmd_o.op = gsu_pkg::OP_START;
        status_d = gsu_pkg::ST_CONT;
        state_d  = S_OUT;
      end
      S_PD: begin
        if (stat_i.done) begin
          if (stat_i.neg) begin
            status_d = gsu_pkg::ST_MISS;
            state_d  = S_OUT;
          end else begin
            cmd_o.op = gsu_pkg::OP_PUSH;
            state_d  = S_DISP;
          end
        end
      end
      S_DISP: begin
        cmd_o.perm = gsu_pkg::PERM_ABC;
        face_d     = gsu_pkg::PERM_ABC;
        case (stat_i.cnt)
          3'd1: begin
            status_d = gsu_pkg::ST_CONT;
            state_d  = S_OUT;
          end
          3'd2: begin
            cmd_o.op = gsu_pkg::OP_LOAD;
            state_d  = S_LINE_D;
          end
          3'd3: begin
            cmd_o.op = gsu_pkg::OP_LOAD;
            tetra_d  = 1'b0;
            state_d  = S_FACE_C;
          end
          default: begin
            cmd_o.op = gsu_pkg::OP_LOAD;
            tetra_d  = 1'b1;
            state_d  = S_FACE_C;
          end
        endcase
      end
      S_LINE_D: begin
        if (stat_i.done) begin
          if (stat_i.pos) begin
            state_d = S_LINE_C1;
          end else begin
            cmd_o.op = gsu_pkg::OP_LINE_DROP;
            status_d = gsu_pkg::ST_CONT;
            state_d  = S_OUT;
          end
        end
      end
      S_LINE_C1: if (stat_i.done) state_d = S_LINE_C2;
      S_LINE_C2: begin
        if (stat_i.done) begin
          cmd_o.op = gsu_pkg::OP_LINE_KEEP;
          status_d = gsu_pkg::ST_CONT;
          state_d  = S_OUT;
        end
      end
      S_FACE_C: if (stat_i.done) state_d = tetra_q ? S_FACE_D : S_TRI_C1;
      S_FACE_D: begin
        if (stat_i.done) begin
          if (stat_i.pos) begin
            state_d = S_TRI_C1;
          end else if (face_q == gsu_pkg::LAST_FACE) begin
            status_d = gsu_pkg::ST_HIT;
            state_d  = S_OUT;
          end else begin
            face_d     = face_q + 2'd1;
            cmd_o.op   = gsu_pkg::OP_LOAD;
            cmd_o.perm = face_q + 2'd1;
            state_d    = S_FACE_C;
          end
        end
      end
      S_TRI_C1: if (stat_i.done) state_d = S_TRI_D1;
      S_TRI_D1: if (stat_i.done) state_d = stat_i.pos ? S_TRI_D2 : S_TRI_C3;
      S_TRI_D2: if (stat_i.done) state_d = stat_i.pos ? S_EDGE_C1 : S_LINE_D;
      S_EDGE_C1: if (stat_i.done) state_d = S_EDGE_C2;
      S_EDGE_C2: begin
        if (stat_i.done) begin
          cmd_o.op = gsu_pkg::OP_EDGE_AC;
          status_d = gsu_pkg::ST_CONT;
          state_d  = S_OUT;
        end
      end
      S_TRI_C3: if (stat_i.done) state_d = S_TRI_D3;
      // cross(ab, abc) faces the origin when (abc x ab) . ao is negative
      S_TRI_D3: if (stat_i.done) state_d = stat_i.neg ? S_LINE_D : S_TRI_D4;
      S_TRI_D4: begin
        if (stat_i.done) begin
          cmd_o.op = stat_i.pos ? gsu_pkg::OP_TRI_UP : gsu_pkg::OP_TRI_DN;
          status_d = gsu_pkg::ST_CONT;
          state_d  = S_OUT;
        end
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sent_q   <= 1'b0;
      tetra_q  <= 1'b0;
      face_q   <= '0;
      status_q <= gsu_pkg::ST_CONT;
    end else begin
      state_q  <= state_d;
      sent_q   <= sent_d;
      tetra_q  <= tetra_d;
      face_q   <= face_d;
      status_q <= status_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = status_q;

endmodule

### sv/gjk_simplex_update_top.sv
// Top level of the GJK simplex update block.
//
//  channel  dir  tdata (low bit up)                              tuser
//  s_axis   in   pt_x[15:0] pt_y[31:16] pt_z[47:32]              operation
//  m_axis   out  status[1:0] next_dir_x/y/z[169:2] size[172:170] -
//
// One beat at a time. An add beat runs its dot and cross products on one
// shared 56x17 multiply-accumulate unit.
// The result holds on m_axis until taken; no input is taken meanwhile.
// Reset clears the point count and the search direction.
`include "gjk_simplex_update_top_defines.svh"
module gjk_simplex_update_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // pt_x, pt_y, pt_z
  input  logic         s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata    // status, next_dir_x, next_dir_y, next_dir_z, size
);

  gsu_pkg::cmd_t     cmd;
  gsu_pkg::dp_stat_t stat;
  gsu_pkg::dir_t     dir;
  gsu_pkg::status_e  status;

  gsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (status),
    .cmd_o       (cmd)
  );

  gsu_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .pt_i   (s_axis_tdata),
    .stat_o (stat),
    .dir_o  (dir)
  );

  // Result beat
  assign m_axis_tdata = {3'b000, stat.cnt, dir[2], dir[1], dir[0], status};

  `GSU_ASSERT(a_no_overlap, m_axis_tvalid |-> !s_axis_tready, "input taken while result pending")
  `GSU_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "block not busy after a beat")
  `GSU_ASSERT(a_hit_full, m_axis_tvalid && (m_axis_tdata[1:0] == gsu_pkg::ST_HIT) |-> m_axis_tdata[172:170] == gsu_pkg::MAX_PTS, "collision without a full simplex")

endmodule

### bench/gsu_checker.sv
// Checker for the GJK simplex update block: predicts each result and compares.
module gsu_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // pt_x, pt_y, pt_z
  input  logic         s_axis_tuser,   // operation
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [175:0] m_axis_tdata,   // status, next_dir_x, next_dir_y, next_dir_z, size
  output int           errors_o,
  output int           pending_o
);

  typedef logic signed [63:0] s64_t;
  typedef struct {
    s64_t x, y, z;
  } vec_t;
  typedef struct {
    gsu_pkg::status_e st;
    logic [55:0]      dx, dy, dz;
    logic [2:0]       size;
  } step_res_t;

  vec_t        held_pts[4];
  int          held_cnt;
  vec_t        cur_dir;
  step_res_t   want_q[$];

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vneg(vec_t a);
    vec_t r;
    r.x = -a.x; r.y = -a.y; r.z = -a.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t u, vec_t v);
    vec_t r;
    r.x = u.y * v.z - u.z * v.y;
    r.y = u.z * v.x - u.x * v.z;
    r.z = u.x * v.y - u.y * v.x;
    return r;
  endfunction

  // exact sign of the dot product using 130-bit sums
  function automatic int dot_sgn(vec_t u, vec_t v);
    logic signed [129:0] acc;
    acc = 130'(u.x) * 130'(v.x) + 130'(u.y) * 130'(v.y) + 130'(u.z) * 130'(v.z);
    if (acc < 0) return -1;
    return (acc != 0) ? 1 : 0;
  endfunction

  task automatic reduce_line(vec_t a, vec_t b);
    vec_t ab, ao;
    ab = vsub(b, a); ao = vneg(a);
    held_pts[0] = a;
    if (dot_sgn(ab, ao) > 0) begin
      held_pts[1] = b;
      held_cnt = 2;
      cur_dir = vcross(vcross(ab, ao), ab);
    end else begin
      held_cnt = 1;
      cur_dir = ao;
    end
  endtask

  task automatic reduce_tri(vec_t a, vec_t b, vec_t c);
    vec_t ab, ac, ao, abc;
    ab = vsub(b, a); ac = vsub(c, a); ao = vneg(a);
    abc = vcross(ab, ac);
    if (dot_sgn(vcross(abc, ac), ao) > 0) begin
      if (dot_sgn(ac, ao) > 0) begin
        held_pts[0] = a; held_pts[1] = c; held_cnt = 2;
        cur_dir = vcross(vcross(ac, ao), ac);
      end else reduce_line(a, b);
    end else if (dot_sgn(vcross(ab, abc), ao) > 0) begin
      reduce_line(a, b);
    end else if (dot_sgn(abc, ao) > 0) begin
      held_pts[0] = a; held_pts[1] = b; held_pts[2] = c; held_cnt = 3;
      cur_dir = abc;
    end else begin
      held_pts[0] = a; held_pts[1] = c; held_pts[2] = b; held_cnt = 3;
      cur_dir = vneg(abc);
    end
  endtask

  task automatic reduce_tetra(vec_t a, vec_t b, vec_t c, vec_t d, output bit enclosed);
    vec_t ab, ac, ad, ao;
    ab = vsub(b, a); ac = vsub(c, a); ad = vsub(d, a); ao = vneg(a);
    enclosed = 0;
    if (dot_sgn(vcross(ab, ac), ao) > 0) reduce_tri(a, b, c);
    else if (dot_sgn(vcross(ac, ad), ao) > 0) reduce_tri(a, c, d);
    else if (dot_sgn(vcross(ad, ab), ao) > 0) reduce_tri(a, d, b);
    else enclosed = 1;
  endtask

  task automatic predict_step(logic add, logic [47:0] pts);
    vec_t p;
    step_res_t r;
    bit hit;
    int n;
    p.x = s64_t'(signed'(pts[15:0]));
    p.y = s64_t'(signed'(pts[31:16]));
    p.z = s64_t'(signed'(pts[47:32]));
    r.st = gsu_pkg::ST_CONT;
    if (!add) begin
      held_pts[0] = p; held_cnt = 1; cur_dir = vneg(p);
    end else if (dot_sgn(p, cur_dir) < 0) begin
      r.st = gsu_pkg::ST_MISS;
    end else begin
      n = (held_cnt < 4) ? held_cnt : 3;
      for (int i = n; i > 0; i--) held_pts[i] = held_pts[i-1];
      held_pts[0] = p;
      held_cnt = n + 1;
      if (held_cnt == 2) reduce_line(held_pts[0], held_pts[1]);
      else if (held_cnt == 3) reduce_tri(held_pts[0], held_pts[1], held_pts[2]);
      else if (held_cnt == 4) begin
        reduce_tetra(held_pts[0], held_pts[1], held_pts[2], held_pts[3], hit);
        if (hit) r.st = gsu_pkg::ST_HIT;
      end
    end
    r.dx = cur_dir.x[55:0]; r.dy = cur_dir.y[55:0]; r.dz = cur_dir.z[55:0];
    r.size = 3'(held_cnt);
    want_q.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, exp_v, $realtime);
    errors_o++;
  endtask

  assign pending_o = want_q.size();

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    step_res_t w;
    if (!rst_ni) begin
      held_cnt = 0;
      cur_dir = '{0, 0, 0};
      want_q.delete();
      errors_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) report("unexpected beat", 0, 0);
        else begin
          w = want_q.pop_front();
          if (m_axis_tdata[1:0] != w.st) report("status", m_axis_tdata[1:0], w.st);
          if (m_axis_tdata[57:2] != w.dx) report("dir_x", m_axis_tdata[57:2], w.dx);
          if (m_axis_tdata[113:58] != w.dy) report("dir_y", m_axis_tdata[113:58], w.dy);
          if (m_axis_tdata[169:114] != w.dz) report("dir_z", m_axis_tdata[169:114], w.dz);
          if (m_axis_tdata[172:170] != w.size) report("size", m_axis_tdata[172:170], w.size);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_step(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

### bench/tb_top.sv
// Testbench top: drives support points into the GJK block and gives the verdict.
module tb_top;

  localparam int CYCLE_LIMIT = 900000;
  localparam logic OPC_START = 1'b0;
  localparam logic OPC_ADD   = 1'b1;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;  // pt_x, pt_y, pt_z
  logic         s_axis_tuser = 0;   // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [175:0] m_axis_tdata;       // status, next_dir_x, next_dir_y, next_dir_z, size
  int           errors, pending;
  int           cycles = 0;
  bit           hold_off = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  gjk_simplex_update_top uut (.*);
  gsu_checker chk (.*, .errors_o(errors), .pending_o(pending));

  // receiver stalls on its own pattern; long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else case ($urandom_range(0, 3))
      0: m_axis_tready <= ($urandom_range(0, 3) != 0);
      1: m_axis_tready <= 1;
      2: m_axis_tready <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready <= m_axis_tready;
    endcase
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] pick_coord(int mode);
    case (mode)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(0, 1536)) - 768);
      3: return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one beat and wait for it to be taken; valid stays up for a following beat
  task automatic send_beat(logic op, logic [47:0] pts);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= pts;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_rand(logic op, int mode);
    send_beat(op, {pick_coord(mode), pick_coord(mode), pick_coord(mode)});
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int burst, md;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // add before any start, then extremes
    send_beat(OPC_ADD, {16'h0001, 16'h0002, 16'h0003});
    send_beat(OPC_START, {16'h8000, 16'h8000, 16'h8000});
    send_beat(OPC_ADD, {16'h7fff, 16'h7fff, 16'h7fff});
    send_beat(OPC_START, {16'h7fff, 16'h0000, 16'h8000});
    send_beat(OPC_ADD, {16'h0000, 16'h0000, 16'h0000});   // zero dot product
    send_beat(OPC_ADD, {16'h0100, 16'h0000, 16'h0000});   // zero search direction: dot is zero again, so no miss
    // enclosing tetrahedron, then adds after the collision
    send_beat(OPC_START, {16'h0000, 16'h0000, 16'h0100});
    send_beat(OPC_ADD, {16'h0000, 16'h0000, 16'hff00});
    send_beat(OPC_ADD, {16'h0000, 16'h0100, 16'h0000});
    send_beat(OPC_ADD, {16'hff00, 16'hff00, 16'h0000});
    send_beat(OPC_ADD, {16'h0100, 16'hff00, 16'h0000});
    send_beat(OPC_ADD, {16'h0000, 16'h0100, 16'h0010});
    send_beat(OPC_ADD, {16'hff80, 16'h0080, 16'h0000});
    wait_drain();
    // long receiver hold-off while the sender keeps offering
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off <= 0;
      end
      repeat (6) send_rand(OPC_ADD, 3);
    join
    wait_drain();
    // random queries: a start followed by a run of adds, in bursts
    for (int q = 0; q < 230; q++) begin
      md = $urandom_range(0, 9) < 7 ? $urandom_range(2, 4) : $urandom_range(0, 4);
      send_rand($urandom_range(0, 19) == 0 ? OPC_ADD : OPC_START, md);
      burst = $urandom_range(2, 8);
      for (int k = 0; k < burst; k++) begin
        send_rand($urandom_range(0, 29) == 0 ? OPC_START : OPC_ADD, md);
        if ($urandom_range(0, 3) == 0) begin
          s_axis_tvalid <= 0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
      if (q % 40 == 20) wait_drain();
    end
    wait_drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
